// File: src/tkel_pkg.sv
// Package for the two-key LCD text entry block.
// Holds the command and state types, key codes and character tables.
// No dependencies.
package tkel_pkg;

   localparam int KeyIdxW = 4;
   localparam int AddrW   = 7;
   localparam int QDepth  = 4;
   localparam int QPtrW   = $clog2(QDepth);

   localparam logic [KeyIdxW-1:0] KEY_1    = 4'd0;
   localparam logic [KeyIdxW-1:0] KEY_2    = 4'd1;
   localparam logic [KeyIdxW-1:0] KEY_4    = 4'd3;
   localparam logic [KeyIdxW-1:0] KEY_5    = 4'd4;
   localparam logic [KeyIdxW-1:0] KEY_6    = 4'd5;
   localparam logic [KeyIdxW-1:0] KEY_8    = 4'd7;
   localparam logic [KeyIdxW-1:0] KEY_9    = 4'd8;
   localparam logic [KeyIdxW-1:0] KEY_STAR = 4'd9;
   localparam logic [KeyIdxW-1:0] KEY_HASH = 4'd11;

   localparam logic [AddrW-1:0] LINE1_HOME = 7'h00;
   localparam logic [AddrW-1:0] LINE2_HOME = 7'h40;
   localparam logic [AddrW-1:0] COL_MASK   = 7'h0F;
   localparam logic [AddrW-1:0] LINE1_END  = 7'h10;
   localparam logic [AddrW-1:0] LINE2_END  = 7'h50;
   localparam logic [7:0]       SET_ADDR   = 8'h80;
   localparam logic [7:0]       CHAR_SPACE = 8'h20;

   localparam logic [7:0] LETTER_TAB [0:7][0:7] = '{
      '{"A", "B", "C", "a", "b", "c", 8'h00, 8'h00},
      '{"D", "E", "F", "d", "e", "f", 8'h00, 8'h00},
      '{"G", "H", "I", "g", "h", "i", 8'h00, 8'h00},
      '{"J", "K", "L", "j", "k", "l", 8'h00, 8'h00},
      '{"M", "N", "O", "m", "n", "o", 8'h00, 8'h00},
      '{"P", "Q", "R", "S", "p", "q", "r", "s"},
      '{"T", "U", "V", "t", "u", "v", 8'h00, 8'h00},
      '{"W", "X", "Y", "Z", "w", "x", "y", "z"}
   };

   localparam logic [7:0] KEY_CHAR_TAB [0:11] = '{
      "1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "0", "#"
   };

   typedef struct packed {
      logic             register_select;
      logic [7:0]       lcd_byte;
      logic [AddrW-1:0] cursor_address;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic               pending;
      logic [KeyIdxW-1:0] first_key;
      logic [AddrW-1:0]   cursor;
   } state_type;

endpackage

// File: src/two_key_text_entry_lcd_cursor.sv
// Top level of the two-key LCD text entry block.
// A request is registered in key_ff, decoded by tkel_step and its responses
// are queued. Throughput: one request per cycle while the queue has room for
// two and each request yields at most one response; a line-end write yields
// two, drained one per cycle by the queue while rsp_stall is low.
// Reset clears pending pair, stored key, cursor and the response queue.
module two_key_text_entry_lcd_cursor
   import tkel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_key_vector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_lcd_byte,
   output logic [6:0]  rsp_cursor_address,
   output logic        rsp_last
);

   logic        in_valid_ff, in_valid_in;
   logic [11:0] key_ff;
   state_type   state_ff, state_in;
   logic [1:0]  cmd_cnt;
   cmd_type     cmd0, cmd1, head;
   logic        room2, not_empty, process, take;

   assign process   = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff <= req_key_vector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   tkel_step u_step (
      .key_vector (key_ff),
      .cur_state  (state_ff),
      .nxt_state  (state_in),
      .cmd_cnt    (cmd_cnt),
      .cmd0       (cmd0),
      .cmd1       (cmd1)
   );

   tkel_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (process ? cmd_cnt : 2'd0),
      .push0     (cmd0),
      .push1     (cmd1),
      .pop       (not_empty && !rsp_stall),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   assign rsp_valid           = not_empty;
   assign rsp_register_select = head.register_select;
   assign rsp_lcd_byte        = head.lcd_byte;
   assign rsp_cursor_address  = head.cursor_address;
   assign rsp_last            = head.last;

endmodule

// File: src/tkel_step.sv
// Key decode and pair evaluation: one scan in, up to two LCD commands out.
// Combinational. Depends on tkel_pkg.
module tkel_step
   import tkel_pkg::*;
(
   input  logic [11:0] key_vector,
   input  state_type   cur_state,
   output state_type   nxt_state,
   output logic [1:0]  cmd_cnt,
   output cmd_type     cmd0,
   output cmd_type     cmd1
);

   logic [KeyIdxW-1:0] key_idx;
   logic [KeyIdxW-1:0] k1;
   logic [AddrW-1:0]   cur;
   logic [AddrW-1:0]   inc_addr;
   logic [AddrW-1:0]   back_addr;
   logic [AddrW-1:0]   new_addr;
   logic [7:0]         ch;
   logic               do_write;
   logic               do_set;

   // priority decode, bit 11 wins
   always_comb begin
      key_idx = '0;
      for (int i = 0; i < 12; i++) begin
         if (key_vector[i]) begin
            key_idx = KeyIdxW'(11 - i);
         end
      end
   end

   assign k1        = cur_state.first_key;
   assign cur       = cur_state.cursor;
   assign inc_addr  = cur + 7'd1;
   assign back_addr = inc_addr - 7'd1;

   always_comb begin
      do_write = 1'b0;
      do_set   = 1'b0;
      ch       = CHAR_SPACE;
      new_addr = cur;
      if (k1 >= KEY_2 && k1 <= KEY_9) begin
         if (key_idx < 4'd8) begin
            ch       = LETTER_TAB[k1[2:0] - 3'd1][key_idx[2:0]];
            do_write = (ch != 8'h00);
         end
      end else if (k1 == KEY_HASH) begin
         ch       = KEY_CHAR_TAB[key_idx];
         do_write = 1'b1;
      end else if (k1 == KEY_STAR) begin
         case (key_idx)
            KEY_2: begin
               do_set   = 1'b1;
               new_addr = cur & COL_MASK;
            end
            KEY_4: begin
               if (cur != LINE1_HOME && cur != LINE2_HOME) begin
                  do_set   = 1'b1;
                  new_addr = cur - 7'd1;
               end
            end
            KEY_5: begin
               do_write = 1'b1;
               ch       = CHAR_SPACE;
            end
            KEY_6: begin
               if ((cur & COL_MASK) != COL_MASK) begin
                  do_set   = 1'b1;
                  new_addr = inc_addr;
               end
            end
            KEY_8: begin
               do_set   = 1'b1;
               new_addr = (cur & COL_MASK) | LINE2_HOME;
            end
            KEY_9: begin
               do_set   = 1'b1;
               new_addr = LINE2_HOME;
            end
            KEY_1: begin
               do_set   = 1'b1;
               new_addr = LINE1_HOME;
            end
            default: begin
               do_set = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      nxt_state = cur_state;
      cmd_cnt   = 2'd0;
      cmd0      = '{register_select: 1'b1, lcd_byte: ch, cursor_address: inc_addr,
                    last: 1'b1};
      cmd1      = '{register_select: 1'b0, lcd_byte: SET_ADDR | {1'b0, back_addr},
                    cursor_address: back_addr, last: 1'b1};
      if (key_vector != 12'd0) begin
         if (!cur_state.pending) begin
            nxt_state.pending   = 1'b1;
            nxt_state.first_key = key_idx;
         end else begin
            nxt_state.pending = 1'b0;
            if (do_write) begin
               if (inc_addr == LINE1_END || inc_addr == LINE2_END) begin
                  cmd_cnt          = 2'd2;
                  cmd0.last        = 1'b0;
                  nxt_state.cursor = back_addr;
               end else begin
                  cmd_cnt          = 2'd1;
                  nxt_state.cursor = inc_addr;
               end
            end else if (do_set) begin
               cmd_cnt              = 2'd1;
               cmd0.register_select = 1'b0;
               cmd0.lcd_byte        = SET_ADDR | {1'b0, new_addr};
               cmd0.cursor_address  = new_addr;
               nxt_state.cursor     = new_addr;
            end
         end
      end
   end

endmodule

// File: src/tkel_rsp_queue.sv
// Response queue: takes up to two commands per cycle, delivers one per cycle while popped.
// Depends on tkel_pkg.
module tkel_rsp_queue
   import tkel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_cnt,
   input  cmd_type    push0,
   input  cmd_type    push1,
   input  logic       pop,
   output cmd_type    head,
   output logic       not_empty,
   output logic       room2
);

   cmd_type          entry_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]   count_ff, count_in;
   logic [QPtrW-1:0] wr_ptr_nx;

   assign wr_ptr_nx = wr_ptr_ff + QPtrW'(1);
   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room2     = (count_ff <= (QPtrW+1)'(QDepth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPtrW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QPtrW'(pop);
      count_in  = count_ff + (QPtrW+1)'(push_cnt) - (QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
